FILE: hdl/mvs_pkg.sv
// Shared constants, types and helpers for the majority-vote sketch.
package mvs_pkg;

    localparam int ROWS_DEF      = 4;
    localparam int BUCKETS_DEF   = 1024;
    localparam int KEY_BYTES_DEF = 4;

    localparam int CNT_W  = 48;
    localparam int KEY_W  = 32;
    localparam int AMT_W  = 32;
    localparam int SEED_W = 64;
    localparam int NSEEDS = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0_SEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_SEED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_SEED = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_SEED = 2'd3;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [63:0] MM_M = 64'hc6a4a7935bd1e995;
    localparam int          MM_R = 47;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic clearing;
    } t_bk_stat;

    // saturating 48-bit add
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

endpackage

FILE: hdl/mvs_item_if.sv
// Input channel: one beat is an update or a point query.
interface mvs_item_if;
    import mvs_pkg::*;
    logic             valid;
    logic             ready;
    logic             op;
    logic [KEY_W-1:0] flow_key;
    logic [AMT_W-1:0] amount;

    modport source (output valid, op, flow_key, amount, input ready);
    modport sink   (input valid, op, flow_key, amount, output ready);
endinterface

FILE: hdl/mvs_result_if.sv
// Output channel: one beat per query.
interface mvs_result_if;
    import mvs_pkg::*;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] upper_estimate;
    logic [CNT_W-1:0] lower_estimate;
    logic [CNT_W-1:0] total_count;

    modport source (output valid, upper_estimate, lower_estimate, total_count, input ready);
    modport sink   (input valid, upper_estimate, lower_estimate, total_count, output ready);
endinterface

FILE: hdl/mvs_queue.sv
// Small FIFO between the hash front and the bucket back end.
module mvs_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end
endmodule

FILE: hdl/mvs_front.sv
// Front end: takes beats, holds the seeds, hashes the key for every row.
module mvs_front import mvs_pkg::*; #(
    parameter int ROWS      = ROWS_DEF,
    parameter int BUCKETS   = BUCKETS_DEF,
    parameter int KEY_BYTES = KEY_BYTES_DEF,
    parameter int SW        = $clog2(ROWS * BUCKETS),
    parameter int EW        = 1 + KEY_W + AMT_W + ROWS * SW
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mvs_item_if.sink             i_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SEED_W-1:0]    i_cfg_data,
    input  t_bk_stat             i_bk_stat,
    output logic                 o_push,
    output logic [EW-1:0]        o_entry,
    input  logic                 i_q_full
);
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IW   = $clog2(BUCKETS);
    localparam bit LONG = (KEY_BYTES >= 8);
    localparam logic [2:0] NMUL_M1 = LONG ? 3'd3 : 3'd1;
    localparam logic [63:0] NM = 64'(KEY_BYTES) * MM_M;
    localparam logic [KEY_W-1:0] KMASK = (KEY_BYTES >= 4) ? {KEY_W{1'b1}}
                                       : KEY_W'((64'd1 << (8 * KEY_BYTES)) - 64'd1);
    // reciprocal of the bucket count, floor(2^32 / BUCKETS)
    localparam logic [31:0] MU    = 32'(64'h1_0000_0000 / 64'(BUCKETS));
    localparam logic [31:0] MOD_B = 32'(BUCKETS);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_MOD  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [SEED_W-1:0] r_seed [NSEEDS];
    logic [1:0]        r_state;
    logic              r_op;
    logic [KEY_W-1:0]  r_key;
    logic [AMT_W-1:0]  r_amt;
    logic [RW-1:0]     r_row;
    logic [SW-1:0]     r_base;
    logic [ROWS*SW-1:0] r_slots;
    logic [63:0]       r_x;
    logic [63:0]       r_acc;
    logic [63:0]       r_prod;
    logic [1:0]        r_mph;
    logic [2:0]        r_mcnt;
    logic [IW-1:0]     r_rem;
    logic [1:0]        r_dig;
    logic [IW:0]       r_t;

    logic [KEY_W-1:0]  key_m;
    logic [63:0]       seed_nm, seed_nm_nx;
    logic [63:0]       x_init_nx;
    logic [31:0]       mul_a, mul_b;
    logic [63:0]       mres, mres_xs;
    logic [31:0]       mod_y;
    logic [IW-1:0]     rem_nx;
    logic              accept;

    assign key_m   = i_item.flow_key & KMASK;
    assign seed_nm = r_seed[2'(r_row)] ^ NM;
    // seed of the row that follows
    assign seed_nm_nx = r_seed[2'(r_row + 1'b1)] ^ NM;
    assign x_init_nx  = LONG ? {32'd0, r_key} : (seed_nm_nx ^ {32'd0, r_key});

    assign accept       = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == F_IDLE) && !i_bk_stat.clearing;

    // one 32x32 multiplier: three partial products of x * M mod 2^64 while hashing,
    // the reciprocal product of the running remainder while reducing
    assign mul_a   = (r_state == F_MOD) ? mod_y
                   : (r_mph == 2'd2) ? r_x[63:32] : r_x[31:0];
    assign mul_b   = (r_state == F_MOD) ? MU
                   : (r_mph == 2'd1) ? MM_M[63:32] : MM_M[31:0];
    assign mres    = r_acc + {r_prod[31:0], 32'd0};
    assign mres_xs = mres ^ (mres >> MM_R);

    // hash mod BUCKETS, 16 bits per step from the top: rem = (rem*2^16 + digit) mod B
    assign mod_y  = (32'(r_rem) << 16) | {16'd0, r_x[63:48]};
    assign rem_nx = (r_t >= (IW+1)'(BUCKETS)) ? IW'(r_t - (IW+1)'(BUCKETS)) : IW'(r_t);

    assign o_push  = (r_state == F_PUSH);
    assign o_entry = {r_op, r_key, r_amt, r_slots};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NSEEDS; i++) begin
                r_seed[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROW0_SEED: r_seed[0] <= i_cfg_data;
                REG_ROW1_SEED: r_seed[1] <= i_cfg_data;
                REG_ROW2_SEED: r_seed[2] <= i_cfg_data;
                REG_ROW3_SEED: r_seed[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_mph   <= '0;
            r_mcnt  <= '0;
            r_row   <= '0;
            r_dig   <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_op    <= i_item.op;
                        r_key   <= key_m;
                        r_amt   <= i_item.amount;
                        r_row   <= '0;
                        r_base  <= '0;
                        r_mph   <= '0;
                        r_mcnt  <= '0;
                        r_x     <= LONG ? {32'd0, key_m}
                                        : (r_seed[0] ^ NM ^ {32'd0, key_m});
                        r_state <= F_MUL;
                    end
                end
                F_MUL: begin
                    r_mph <= r_mph + 1'b1;
                    if (r_mph == 2'd1) begin
                        r_acc <= r_prod;
                    end else if (r_mph == 2'd2) begin
                        r_acc <= r_acc + {r_prod[31:0], 32'd0};
                    end else if (r_mph == 2'd3) begin
                        r_mcnt <= r_mcnt + 1'b1;
                        // long keys mix the seed in after the key block
                        if (LONG && r_mcnt == 3'd1) begin
                            r_x <= seed_nm ^ mres;
                        end else begin
                            r_x <= mres_xs;
                        end
                        if (r_mcnt == NMUL_M1) begin
                            r_rem   <= '0;
                            r_dig   <= '0;
                            r_state <= F_MOD;
                        end
                    end
                end
                F_MOD: begin
                    // phase 0 forms the quotient estimate, 1 the partial remainder,
                    // 2 the final correction
                    r_mph <= (r_mph == 2'd2) ? 2'd0 : r_mph + 1'b1;
                    if (r_mph == 2'd1) begin
                        r_t <= (IW+1)'(mod_y - r_prod[63:32] * MOD_B);
                    end else if (r_mph == 2'd2) begin
                        r_rem <= rem_nx;
                        r_dig <= r_dig + 1'b1;
                        if (r_dig == 2'd3) begin
                            r_slots[r_row*SW +: SW] <= r_base + SW'(rem_nx);
                            if (r_row == RW'(ROWS - 1)) begin
                                r_state <= F_PUSH;
                            end else begin
                                r_row   <= r_row + 1'b1;
                                r_base  <= r_base + SW'(BUCKETS);
                                r_x     <= x_init_nx;
                                r_mcnt  <= '0;
                                r_state <= F_MUL;
                            end
                        end else begin
                            r_x <= {r_x[47:0], 16'd0};
                        end
                    end
                end
                F_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    a_mul_phase_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_IDLE) |-> (r_mph == 2'd0))
        else $error("multiplier phase not at rest while idle");
    a_push_full_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_PUSH) |-> (r_row == RW'(ROWS - 1)))
        else $error("entry pushed before all rows hashed");
    a_mod_from_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == F_MOD) |-> ($past(r_state) == F_MUL && $past(r_mph) == 2'd3))
        else $error("modulo started without a finished hash");
endmodule

FILE: hdl/mvs_back.sv
// Back end: bucket store, vote update and query estimates.
module mvs_back import mvs_pkg::*; #(
    parameter int ROWS    = ROWS_DEF,
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int SW      = $clog2(ROWS * BUCKETS),
    parameter int EW      = 1 + KEY_W + AMT_W + ROWS * SW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  logic [EW-1:0] i_entry,
    output logic          o_pop,
    output t_bk_stat      o_stat,
    mvs_result_if.source  o_result
);
    localparam int D  = ROWS * BUCKETS;
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic [2:0] B_CLEAR = 3'd0;
    localparam logic [2:0] B_IDLE  = 3'd1;
    localparam logic [2:0] B_RD    = 3'd2;
    localparam logic [2:0] B_CALC  = 3'd3;
    localparam logic [2:0] B_ACC   = 3'd4;
    localparam logic [2:0] B_EMIT  = 3'd5;

    logic [CNT_W-1:0] mem_total [D];
    logic [CNT_W-1:0] mem_votes [D];
    logic [KEY_W-1:0] mem_key   [D];
    logic             mem_valid [D];

    logic [2:0]         r_state;
    logic [SW-1:0]      r_clr_addr;
    logic               r_op;
    logic [KEY_W-1:0]   r_key;
    logic [AMT_W-1:0]   r_amt;
    logic [ROWS*SW-1:0] r_slots;
    logic [RW-1:0]      r_row;
    logic [CNT_W-1:0]   r_rd_total, r_rd_votes;
    logic [KEY_W-1:0]   r_rd_key;
    logic               r_rd_valid;
    logic [CNT_W-1:0]   r_est, r_v, r_up, r_low, r_gtot;
    logic               r_match;
    logic               r_oval;
    logic [CNT_W-1:0]   r_o_up, r_o_low, r_o_tot;

    logic [SW-1:0]    cur_slot, wr_addr;
    logic             wr_en, clearing, match;
    logic [CNT_W-1:0] amt_w, w_total, w_votes, est_raw;
    logic [KEY_W-1:0] w_key;
    logic             w_valid;

    assign clearing        = (r_state == B_CLEAR);
    assign o_stat.clearing = clearing;
    assign cur_slot        = r_slots[r_row*SW +: SW];
    assign amt_w           = CNT_W'(r_amt);
    assign match           = r_rd_valid && (r_rd_key == r_key);
    assign o_pop           = (r_state == B_IDLE) && i_q_valid;

    // vote rule for one bucket
    always_comb begin
        w_total = sat_add(r_rd_total, amt_w);
        w_key   = r_rd_key;
        w_valid = 1'b1;
        if (!r_rd_valid) begin
            w_key   = r_key;
            w_votes = amt_w;
        end else if (r_rd_key == r_key) begin
            w_votes = sat_add(r_rd_votes, amt_w);
        end else if (amt_w > r_rd_votes) begin
            w_votes = amt_w - r_rd_votes;
            w_key   = r_key;
        end else begin
            w_votes = r_rd_votes - amt_w;
        end
        if (clearing) begin
            w_total = '0;
            w_votes = '0;
            w_key   = '0;
            w_valid = 1'b0;
        end
    end

    assign est_raw = (r_rd_total >= r_rd_votes) ? (r_rd_total - r_rd_votes) >> 1 : '0;
    assign wr_en   = clearing || (r_state == B_CALC && r_op == OP_UPDATE);
    assign wr_addr = clearing ? r_clr_addr : cur_slot;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_total[wr_addr] <= w_total;
            mem_votes[wr_addr] <= w_votes;
            mem_key[wr_addr]   <= w_key;
            mem_valid[wr_addr] <= w_valid;
        end
        if (r_state == B_RD) begin
            r_rd_total <= mem_total[cur_slot];
            r_rd_votes <= mem_votes[cur_slot];
            r_rd_key   <= mem_key[cur_slot];
            r_rd_valid <= mem_valid[cur_slot];
        end
    end

    assign o_result.valid          = r_oval;
    assign o_result.upper_estimate = r_o_up;
    assign o_result.lower_estimate = r_o_low;
    assign o_result.total_count    = r_o_tot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_CLEAR;
            r_clr_addr <= '0;
            r_row      <= '0;
            r_gtot     <= '0;
            r_oval     <= 1'b0;
        end else begin
            // the emit state reloads the result register itself
            if (o_result.ready && r_state != B_EMIT) begin
                r_oval <= 1'b0;
            end
            unique case (r_state)
                B_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == SW'(D - 1)) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (i_q_valid) begin
                        {r_op, r_key, r_amt, r_slots} <= i_entry;
                        r_row   <= '0;
                        r_state <= B_RD;
                    end
                end
                B_RD: r_state <= B_CALC;
                B_CALC: begin
                    if (r_op == OP_UPDATE) begin
                        if (r_row == '0) begin
                            r_gtot <= sat_add(r_gtot, amt_w);
                        end
                        if (r_row == RW'(ROWS - 1)) begin
                            r_state <= B_IDLE;
                        end else begin
                            r_row   <= r_row + 1'b1;
                            r_state <= B_RD;
                        end
                    end else begin
                        r_est   <= match ? sat_add(est_raw, r_rd_votes) : est_raw;
                        r_match <= match;
                        r_v     <= r_rd_votes;
                        r_state <= B_ACC;
                    end
                end
                B_ACC: begin
                    if (r_row == '0 || r_est < r_up) begin
                        r_up <= r_est;
                    end
                    if (r_match && (r_row == '0 || r_v > r_low)) begin
                        r_low <= r_v;
                    end else if (r_row == '0) begin
                        r_low <= '0;
                    end
                    if (r_row == RW'(ROWS - 1)) begin
                        r_state <= B_EMIT;
                    end else begin
                        r_row   <= r_row + 1'b1;
                        r_state <= B_RD;
                    end
                end
                B_EMIT: begin
                    if (!r_oval || o_result.ready) begin
                        r_oval  <= 1'b1;
                        r_o_up  <= r_up;
                        r_o_low <= r_low;
                        r_o_tot <= r_gtot;
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !r_oval)
        else $error("result shown during clearing pass");
    a_clear_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (clearing && r_clr_addr == SW'(D - 1)) |=> (r_state == B_IDLE))
        else $error("clearing pass overran");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == B_IDLE && !clearing))
        else $error("queue popped while busy");
    a_emit_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_EMIT) |-> (r_op == OP_QUERY))
        else $error("update produced a result");
endmodule

FILE: hdl/majority_vote_sketch_top.sv
// Top level of the majority-vote heavy-flow sketch.
//
//  channel   dir  handshake      payload
//  i_item    in   valid/ready    op, flow_key, amount
//  o_result  out  valid/ready    upper_estimate, lower_estimate, total_count
//  i_cfg_*   in   write enable   i_cfg_idx (seed row), i_cfg_data (64-bit seed)
//
// The front takes a new beat only after it has pushed the last one to the queue. It does
// M = 2 multiplies per row (4 for eight-byte keys), hashes one row at a time through one
// 32x32 multiplier and reduces modulo BUCKETS in four 16-bit steps, reusing that
// multiplier for the reciprocal.
// The back end pops an entry, then reads and writes back each row in turn for an update,
// or reads, estimates and accumulates each row, then loads the result register, for a query.
// After reset a clearing pass over all ROWS*BUCKETS slots zeroes the store; no beat
// is taken until it ends. A two-deep queue lets the front hash the next beat
// while the back end waits on a stalled result; the result register frees the back end.
module majority_vote_sketch_top import mvs_pkg::*; #(
    parameter int ROWS      = ROWS_DEF,
    parameter int BUCKETS   = BUCKETS_DEF,
    parameter int KEY_BYTES = KEY_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mvs_item_if.sink             i_item,
    mvs_result_if.source         o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SEED_W-1:0]    i_cfg_data
);
    localparam int SW = $clog2(ROWS * BUCKETS);
    localparam int EW = 1 + KEY_W + AMT_W + ROWS * SW;

    t_bk_stat      bk_stat;
    logic          q_push, q_full, q_pop, q_valid;
    logic [EW-1:0] q_in, q_out;

    // hash front
    mvs_front #(
        .ROWS(ROWS), .BUCKETS(BUCKETS), .KEY_BYTES(KEY_BYTES), .SW(SW), .EW(EW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_bk_stat  (bk_stat),
        .o_push     (q_push),
        .o_entry    (q_in),
        .i_q_full   (q_full)
    );

    // decoupling queue
    mvs_queue #(.W(EW), .DEPTH(2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    // bucket store and estimates
    mvs_back #(.ROWS(ROWS), .BUCKETS(BUCKETS), .SW(SW), .EW(EW)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_entry   (q_out),
        .o_pop     (q_pop),
        .o_stat    (bk_stat),
        .o_result  (o_result)
    );
endmodule

FILE: tb/tb_majority_vote_sketch_top.sv
// Self-checking testbench for the majority-vote heavy-flow sketch top level.
`timescale 1ns / 1ps

module tb_majority_vote_sketch_top;
    import mvs_pkg::*;

    localparam int ROWS      = ROWS_DEF;
    localparam int BUCKETS   = BUCKETS_DEF;
    localparam int SLOTS     = ROWS * BUCKETS;
    // drain wait after the last answer is back; allow a generous margin
    localparam int SETTLE    = 600;
    localparam int WDOG_MAX  = 60000;
    localparam int N_PHASES  = 5;
    localparam int PER_PHASE = 180;

    typedef struct packed {
        logic [CNT_W-1:0] upper;
        logic [CNT_W-1:0] lower;
        logic [CNT_W-1:0] total;
    } t_estimate;

    // Scoreboard: mirrors the sketch store and queues expected query answers.
    class sketch_board;
        logic [SEED_W-1:0] seed [NSEEDS];
        logic [CNT_W-1:0]  slot_total [SLOTS];
        logic [CNT_W-1:0]  slot_votes [SLOTS];
        logic [KEY_W-1:0]  slot_key   [SLOTS];
        bit                slot_used  [SLOTS];
        logic [CNT_W-1:0]  grand;
        t_estimate         answers [$];
        int                errors;

        function new();
            for (int i = 0; i < NSEEDS; i++) seed[i] = '0;
            for (int i = 0; i < SLOTS; i++) begin
                slot_total[i] = '0;
                slot_votes[i] = '0;
                slot_key[i]   = '0;
                slot_used[i]  = 0;
            end
            grand  = '0;
            errors = 0;
        endfunction

        function logic [CNT_W-1:0] cnt_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
            logic [CNT_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
        endfunction

        // 64-bit murmur over a four-byte key, reduced to a slot of the row
        function int slot_of(int row, logic [KEY_W-1:0] k);
            logic [63:0] h;
            h = seed[row] ^ (64'd4 * MM_M);
            h = h ^ {32'b0, k};
            h = h * MM_M;
            h = h ^ (h >> MM_R);
            h = h * MM_M;
            h = h ^ (h >> MM_R);
            return row * BUCKETS + int'(h % BUCKETS);
        endfunction

        function void note_item(logic op, logic [KEY_W-1:0] k, logic [AMT_W-1:0] amt);
            logic [CNT_W-1:0] a, t, v, est, up, low;
            t_estimate ans;
            int s;
            a = {16'b0, amt};
            if (op == OP_UPDATE) begin
                grand = cnt_add(grand, a);
                for (int r = 0; r < ROWS; r++) begin
                    s = slot_of(r, k);
                    slot_total[s] = cnt_add(slot_total[s], a);
                    if (!slot_used[s]) begin
                        slot_used[s]  = 1;
                        slot_key[s]   = k;
                        slot_votes[s] = a;
                    end else if (slot_key[s] == k) begin
                        slot_votes[s] = cnt_add(slot_votes[s], a);
                    end else if (a > slot_votes[s]) begin
                        slot_votes[s] = a - slot_votes[s];
                        slot_key[s]   = k;
                    end else begin
                        slot_votes[s] = slot_votes[s] - a;
                    end
                end
            end else begin
                up  = '0;
                low = '0;
                for (int r = 0; r < ROWS; r++) begin
                    s   = slot_of(r, k);
                    t   = slot_total[s];
                    v   = slot_votes[s];
                    est = (t >= v) ? (t - v) >> 1 : '0;
                    if (slot_used[s] && slot_key[s] == k) begin
                        est = cnt_add(est, v);
                        if (v > low) low = v;
                    end
                    if (r == 0 || est < up) up = est;
                end
                ans = '{upper: up, lower: low, total: grand};
                answers.insert(answers.size(), ans);
            end
        endfunction

        function void check_result(t_estimate got);
            t_estimate exp;
            if (answers.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: up=%h low=%h tot=%h",
                             got.upper, got.lower, got.total);
                return;
            end
            exp = answers.pop_front();
            if (got !== exp) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp up=%h low=%h tot=%h, got up=%h low=%h tot=%h",
                             exp.upper, exp.lower, exp.total,
                             got.upper, got.lower, got.total);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [SEED_W-1:0]    i_cfg_data;

    mvs_item_if   item_ch ();
    mvs_result_if res_ch ();

    majority_vote_sketch_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .o_result   (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    sketch_board board;
    bit          no_gaps;
    int          idle_cycles = 0;
    logic [KEY_W-1:0] key_pool [8];

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // mostly short gaps, now and then a long one; none while no_gaps is set
    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // first key after k that lands in the same row-0 bucket as k
    function automatic logic [KEY_W-1:0] row0_partner(logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] c;
        c = k + 1;
        while (board.slot_of(0, c) != board.slot_of(0, k)) c = c + 1;
        return c;
    endfunction

    // pool: two groups of row-0 colliders plus loose keys, so votes get contested
    task automatic build_pool();
        key_pool[0] = $urandom;
        key_pool[1] = row0_partner(key_pool[0]);
        key_pool[2] = row0_partner(key_pool[1]);
        key_pool[3] = $urandom;
        key_pool[4] = row0_partner(key_pool[3]);
        for (int i = 5; i < 8; i++) key_pool[i] = $urandom;
    endtask

    // one beat on the item channel; returns at the accepting edge
    task automatic send_item(logic op, logic [KEY_W-1:0] k, logic [AMT_W-1:0] amt);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid    <= 1'b1;
        item_ch.op       <= op;
        item_ch.flow_key <= k;
        item_ch.amount   <= amt;
        do @(posedge i_clk); while (!item_ch.ready);
    endtask

    // hold off until every query answer is back, then let the pipe drain
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // block is idle here; one register per edge
    task automatic write_seeds(logic [SEED_W-1:0] s0, logic [SEED_W-1:0] s1,
                               logic [SEED_W-1:0] s2, logic [SEED_W-1:0] s3);
        logic [SEED_W-1:0] vals [NSEEDS];
        vals = '{s0, s1, s2, s3};
        for (int i = 0; i < NSEEDS; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(i);
            i_cfg_data <= vals[i];
            board.seed[i] = vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_item();
        logic op;
        logic [KEY_W-1:0] k;
        logic [AMT_W-1:0] amt;
        int r;
        op = ($urandom_range(0, 99) < 35) ? OP_QUERY : OP_UPDATE;
        r  = $urandom_range(0, 9);
        if (r < 6)      k = key_pool[$urandom_range(0, 7)];
        else if (r < 8) k = $urandom;
        else            k = $urandom_range(0, 15);
        r = $urandom_range(0, 9);
        if (r == 0)     amt = '0;
        else if (r == 1) amt = '1;
        else if (r < 6) amt = $urandom_range(1, 100);
        else            amt = $urandom;
        send_item(op, k, amt);
    endtask

    // directed opening: extremes, empty buckets, vote tie and key takeover
    task automatic directed_part();
        logic [KEY_W-1:0] ka, kb;
        ka = 32'h0000_1234;
        kb = row0_partner(ka);
        send_item(OP_QUERY,  32'h1234_5678, '0);   // nothing stored yet
        send_item(OP_UPDATE, '0, '0);
        send_item(OP_QUERY,  '0, '1);
        send_item(OP_UPDATE, '1, '1);
        send_item(OP_QUERY,  '1, '0);
        send_item(OP_UPDATE, ka, 32'd5);
        send_item(OP_UPDATE, kb, 32'd5);           // tie: votes to zero, key kept
        send_item(OP_QUERY,  ka, '0);
        send_item(OP_QUERY,  kb, '0);
        send_item(OP_UPDATE, kb, 32'd7);           // takes over the row-0 bucket
        send_item(OP_QUERY,  ka, '0);
        send_item(OP_QUERY,  kb, '0);
        send_item(OP_UPDATE, ka, '1);
        send_item(OP_UPDATE, ka, '1);
        send_item(OP_UPDATE, kb, 32'd3);           // other key, votes shrink
        send_item(OP_QUERY,  ka, '0);
        send_item(OP_QUERY,  kb, '0);
        send_item(OP_UPDATE, 32'hAAAA_5555, 32'h8000_0001);
        send_item(OP_QUERY,  32'hAAAA_5555, '0);
        send_item(OP_QUERY,  32'h5555_AAAA, '0);
    endtask

    // receiver: ready drops for random stretches
    initial begin
        int gap;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // accepted beats on both channels go to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && item_ch.valid && item_ch.ready)
            board.note_item(item_ch.op, item_ch.flow_key, item_ch.amount);
        if (i_rst_n && res_ch.valid && res_ch.ready)
            board.check_result('{upper: res_ch.upper_estimate,
                                 lower: res_ch.lower_estimate,
                                 total: res_ch.total_count});
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("majority_vote_sketch_top test failed");
            $finish;
        end
    end

    initial begin
        board         = new();
        no_gaps       = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        item_ch.valid    = 1'b0;
        item_ch.op       = OP_UPDATE;
        item_ch.flow_key = '0;
        item_ch.amount   = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // seeds at reset value (zero) for the directed beats
        directed_part();
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: write_seeds('1, '1, '1, '1);
                1: write_seeds(64'($urandom), {$urandom, $urandom}, '0, '1);
                2: write_seeds({$urandom, $urandom}, {$urandom, $urandom},
                               {$urandom, $urandom}, {$urandom, $urandom});
                3: write_seeds('0, '0, '0, '0);
                default: write_seeds({$urandom, $urandom}, 64'h8000_0000_0000_0001,
                                     64'h0123_4567_89AB_CDEF, {$urandom, $urandom});
            endcase
            build_pool();
            no_gaps = (p == 2);
            for (int n = 0; n < PER_PHASE; n++) begin
                if (n == PER_PHASE / 2) drain();   // mid-phase hold-off
                random_item();
            end
            no_gaps = 0;
            drain();
        end

        // drain has already waited out answers and pipeline
        if (board.answers.size() != 0) board.errors += board.answers.size();
        if (board.errors == 0)
            $display("majority_vote_sketch_top test passed");
        else
            $display("majority_vote_sketch_top test failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/mvs_pkg.sv
hdl/mvs_item_if.sv
hdl/mvs_result_if.sv
hdl/mvs_queue.sv
hdl/mvs_front.sv
hdl/mvs_back.sv
hdl/majority_vote_sketch_top.sv
tb/tb_majority_vote_sketch_top.sv
